@@ src/ladsr_pkg.sv @@
// Shared types, widths and codes of the linear ADSR envelope generator.
package ladsr_pkg;

    localparam int LEN_BITS  = 16;
    localparam int FRAC_BITS = 15;

    localparam int REG_W   = 16;
    localparam int ENV_W   = 16;
    localparam int INT_W   = 16;
    localparam int LEN_W   = LEN_BITS;
    localparam int LVL_W   = FRAC_BITS + 1;
    localparam int Q_W     = LVL_W;
    localparam int NUM_W   = LEN_W + LVL_W;
    localparam int MUL_W   = (LEN_W > LVL_W) ? LEN_W : LVL_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int CNT_W   = $clog2(Q_W + 1);
    localparam int ONE_INT = 1 << FRAC_BITS;

    localparam logic [LVL_W-1:0] ONE = LVL_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_ON      = 2'd1,
        ACT_OFF     = 2'd2,
        ACT_ILLEGAL = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_BUSY    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_RELEASE = 2'd2,
        REG_SUSTAIN = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] numer;
        logic [LEN_W-1:0] denom;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic [ENV_W-1:0] envelope;
        t_status          status;
        t_phase           phase;
    } t_result;

endpackage

@@ src/ladsr_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
module ladsr_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ladsr_pkg::t_div_req i_req,
    output ladsr_pkg::t_div_rsp o_rsp
);

    logic [ladsr_pkg::LEN_W-1:0] r_rem;
    logic [ladsr_pkg::LEN_W-1:0] r_den;
    logic [ladsr_pkg::Q_W-1:0]   r_sh;
    logic [ladsr_pkg::CNT_W-1:0] r_cnt;
    logic                        r_done;

    logic [ladsr_pkg::LEN_W:0] trial;
    logic [ladsr_pkg::LEN_W:0] diff;
    logic                      fits;

    // Partial remainder with the next numerator bit brought down.
    assign trial = {r_rem, r_sh[ladsr_pkg::Q_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                // Quotient fits Q_W bits, so the upper numerator part is below the divisor.
                r_rem <= i_req.numer[ladsr_pkg::NUM_W-1:ladsr_pkg::Q_W];
                r_sh  <= i_req.numer[ladsr_pkg::Q_W-1:0];
                r_den <= i_req.denom;
                r_cnt <= ladsr_pkg::CNT_W'(ladsr_pkg::Q_W);
            end else if (r_cnt != '0) begin
                r_rem  <= fits ? diff[ladsr_pkg::LEN_W-1:0] : trial[ladsr_pkg::LEN_W-1:0];
                r_sh   <= {r_sh[ladsr_pkg::Q_W-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == ladsr_pkg::CNT_W'(1));
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sh;

endmodule

@@ src/ladsr_core.sv @@
// Envelope state, configuration registers and the sequencer around the shared multiplier.
module ladsr_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [ladsr_pkg::REG_W-1:0]       i_cfg_data,
    input  logic                              i_in_acc,
    input  logic [1:0]                        i_action,
    input  logic [ladsr_pkg::INT_W-1:0]       i_intensity,
    input  logic                              i_res_take,
    output logic                              o_busy,
    output logic                              o_res_valid,
    output ladsr_pkg::t_result                o_res,
    output ladsr_pkg::t_div_req               o_div_req,
    input  ladsr_pkg::t_div_rsp               i_div_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENV,
        S_NUM,
        S_DIV,
        S_OUT
    } t_seq;

    t_seq                          r_seq;
    ladsr_pkg::t_phase             r_phase;
    ladsr_pkg::t_status            r_status;
    logic [ladsr_pkg::LEN_W-1:0]   r_step;
    logic [ladsr_pkg::LVL_W-1:0]   r_level;
    logic [ladsr_pkg::LVL_W-1:0]   r_held;
    logic [ladsr_pkg::PROD_W-1:0]  r_prod;
    logic [ladsr_pkg::ENV_W-1:0]   r_env;
    logic                          r_ramp;
    logic                          r_div_start;

    logic [ladsr_pkg::REG_W-1:0]   r_attack;
    logic [ladsr_pkg::REG_W-1:0]   r_decay;
    logic [ladsr_pkg::REG_W-1:0]   r_release;
    logic [ladsr_pkg::REG_W-1:0]   r_sustain;

    logic [ladsr_pkg::LEN_W-1:0]   len_a;
    logic [ladsr_pkg::LEN_W-1:0]   len_d;
    logic [ladsr_pkg::LEN_W-1:0]   len_r;
    logic [ladsr_pkg::LVL_W-1:0]   sus;
    logic [ladsr_pkg::LEN_W-1:0]   step_nx;
    logic [ladsr_pkg::MUL_W-1:0]   mul_a;
    logic [ladsr_pkg::MUL_W-1:0]   mul_b;
    logic [ladsr_pkg::PROD_W-1:0]  mul_p;
    logic [ladsr_pkg::LEN_W-1:0]   denom;
    logic                          over_one;
    ladsr_pkg::t_action            act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= ladsr_pkg::REG_W'(480);
            r_decay   <= ladsr_pkg::REG_W'(480);
            r_release <= ladsr_pkg::REG_W'(480);
            r_sustain <= ladsr_pkg::REG_W'(16384);
        end else if (i_cfg_we) begin
            unique case (ladsr_pkg::t_reg_idx'(i_cfg_index))
                ladsr_pkg::REG_ATTACK:  r_attack  <= i_cfg_data;
                ladsr_pkg::REG_DECAY:   r_decay   <= i_cfg_data;
                ladsr_pkg::REG_RELEASE: r_release <= i_cfg_data;
                ladsr_pkg::REG_SUSTAIN: r_sustain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign len_a    = ladsr_pkg::LEN_W'(r_attack);
    assign len_d    = ladsr_pkg::LEN_W'(r_decay);
    assign len_r    = ladsr_pkg::LEN_W'(r_release);
    assign sus      = (32'(r_sustain) > 32'(ladsr_pkg::ONE_INT)) ?
                      ladsr_pkg::ONE : ladsr_pkg::LVL_W'(r_sustain);
    assign step_nx  = r_step + 1'b1;
    assign over_one = 32'(i_intensity) > 32'(ladsr_pkg::ONE_INT);
    assign act      = ladsr_pkg::t_action'(i_action);

    // Operand select: held times level for the output, the ramp numerator otherwise.
    always_comb begin
        mul_a = ladsr_pkg::MUL_W'(r_held);
        mul_b = ladsr_pkg::MUL_W'(r_level);
        denom = len_a;
        if (r_seq == S_NUM) begin
            unique case (r_phase)
                ladsr_pkg::PH_ATTACK: begin
                    mul_a = ladsr_pkg::MUL_W'(r_step);
                    mul_b = ladsr_pkg::MUL_W'(ladsr_pkg::ONE);
                end
                ladsr_pkg::PH_DECAY: begin
                    mul_a = ladsr_pkg::MUL_W'(ladsr_pkg::ONE - sus);
                    mul_b = ladsr_pkg::MUL_W'(len_d - r_step);
                end
                ladsr_pkg::PH_RELEASE: begin
                    mul_a = ladsr_pkg::MUL_W'(sus);
                    mul_b = ladsr_pkg::MUL_W'(len_r - r_step);
                end
                default: ;
            endcase
        end
        unique case (r_phase)
            ladsr_pkg::PH_DECAY:   denom = len_d;
            ladsr_pkg::PH_RELEASE: denom = len_r;
            default:               denom = len_a;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= S_IDLE;
            r_phase     <= ladsr_pkg::PH_IDLE;
            r_step      <= '0;
            r_level     <= '0;
            r_held      <= '0;
            r_ramp      <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_seq)
                S_IDLE: begin
                    if (i_in_acc) begin
                        r_env    <= '0;
                        r_status <= ladsr_pkg::ST_OK;
                        if (act == ladsr_pkg::ACT_TICK) begin
                            r_seq <= S_ENV;
                        end else begin
                            r_seq <= S_OUT;
                            if (act == ladsr_pkg::ACT_ILLEGAL || over_one) begin
                                r_status <= ladsr_pkg::ST_INVALID;
                            end else if (act == ladsr_pkg::ACT_ON) begin
                                if (r_phase == ladsr_pkg::PH_IDLE) begin
                                    r_held  <= ladsr_pkg::LVL_W'(i_intensity);
                                    r_phase <= ladsr_pkg::PH_ATTACK;
                                    r_step  <= '0;
                                    r_level <= '0;
                                end else if (r_phase != ladsr_pkg::PH_SUSTAIN) begin
                                    r_status <= ladsr_pkg::ST_BUSY;
                                end
                            end else if (r_phase != ladsr_pkg::PH_IDLE &&
                                         r_phase != ladsr_pkg::PH_RELEASE) begin
                                r_phase <= ladsr_pkg::PH_RELEASE;
                                r_step  <= '0;
                                r_level <= sus;
                            end
                        end
                    end
                end
                S_ENV: begin
                    // Capture held times level, then decide where the phase goes.
                    r_prod <= mul_p;
                    r_ramp <= 1'b0;
                    r_seq  <= S_NUM;
                    unique case (r_phase)
                        ladsr_pkg::PH_ATTACK: begin
                            if (step_nx < len_a) begin
                                r_step <= step_nx;
                                r_ramp <= 1'b1;
                            end else begin
                                r_phase <= ladsr_pkg::PH_DECAY;
                                r_step  <= '0;
                                r_level <= ladsr_pkg::ONE;
                            end
                        end
                        ladsr_pkg::PH_DECAY: begin
                            if (step_nx < len_d) begin
                                r_step <= step_nx;
                                r_ramp <= 1'b1;
                            end else begin
                                r_phase <= ladsr_pkg::PH_SUSTAIN;
                                r_step  <= '0;
                                r_level <= sus;
                            end
                        end
                        ladsr_pkg::PH_RELEASE: begin
                            if (step_nx < len_r) begin
                                r_step <= step_nx;
                                r_ramp <= 1'b1;
                            end else begin
                                r_phase <= ladsr_pkg::PH_IDLE;
                                r_step  <= '0;
                                r_held  <= '0;
                                r_level <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_NUM: begin
                    r_env <= ladsr_pkg::ENV_W'(r_prod >> ladsr_pkg::FRAC_BITS);
                    if (r_ramp) begin
                        r_prod      <= mul_p;
                        r_div_start <= 1'b1;
                        r_seq       <= S_DIV;
                    end else begin
                        r_seq <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_level <= (r_phase == ladsr_pkg::PH_DECAY) ?
                                   sus + ladsr_pkg::LVL_W'(i_div_rsp.quot) :
                                   ladsr_pkg::LVL_W'(i_div_rsp.quot);
                        r_seq   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_res_take) begin
                        r_seq <= S_IDLE;
                    end
                end
                default: r_seq <= S_IDLE;
            endcase
        end
    end

    assign o_div_req.start = r_div_start;
    assign o_div_req.numer = ladsr_pkg::NUM_W'(r_prod);
    assign o_div_req.denom = denom;

    assign o_busy         = (r_seq != S_IDLE);
    assign o_res_valid    = (r_seq == S_OUT);
    assign o_res.envelope = r_env;
    assign o_res.status   = r_status;
    assign o_res.phase    = r_phase;

endmodule

@@ src/linear_adsr_envelope_top.sv @@
// Top level of the linear ADSR envelope generator: handshakes, output register, core and divider.
//
// Linear ADSR envelope generator. Each input transfer is a sample tick, a note-on or a note-off,
// and each one yields exactly one result transfer (envelope, status, phase). A tick reports
// held intensity times the current level in Q1.15 and then advances the phase; the attack,
// decay and release ramps are computed on the fly by one shared 16x16 multiplier and a serial
// restoring divider that produces one quotient bit per cycle. The block works on one item at a
// time and holds o_stall high until that item's result has moved into the output register.
// A note item goes through its result and then back to idle. A tick in idle or sustain or at
// the end of a ramp goes through envelope multiply, envelope scale, result and idle. A tick
// inside a ramp goes through envelope multiply, numerator multiply, divider start, divider load,
// the divider iterations, done and result. While the output register is full and stalled, the
// result waits in the sequencer. A finished result waits in the output register while the next
// transfer is accepted. Registers come out of reset at 480 samples for every ramp and half scale
// sustain; write them only while the block is idle. There is no clearing pass after reset.
module linear_adsr_envelope_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_intensity,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_envelope,
    output logic [1:0]  o_status,
    output logic [2:0]  o_phase
);

    ladsr_pkg::t_div_req div_req;
    ladsr_pkg::t_div_rsp div_rsp;
    ladsr_pkg::t_result  core_res;
    logic                core_busy;
    logic                core_valid;
    logic                in_acc;
    logic                res_take;

    logic                r_out_valid;
    ladsr_pkg::t_result  r_out;

    // Accept a new item only while the sequencer is idle.
    assign o_stall = core_busy;
    assign in_acc  = i_valid && !core_busy;

    // Move a finished result into the output register when it is empty or draining.
    assign res_take = core_valid && (!r_out_valid || !i_stall);

    ladsr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_acc    (in_acc),
        .i_action    (i_action),
        .i_intensity (i_intensity),
        .i_res_take  (res_take),
        .o_busy      (core_busy),
        .o_res_valid (core_valid),
        .o_res       (core_res),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    ladsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the payload while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= core_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_envelope = r_out.envelope;
    assign o_status   = r_out.status;
    assign o_phase    = r_out.phase;

endmodule

@@ src/ladsr_checker.sv @@
// Port-level assertions for the linear ADSR envelope generator, bound to the top level.
module ladsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_envelope,
    input logic [1:0]  o_status,
    input logic [2:0]  o_phase
);

    // Block stays busy in the cycle after it takes an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block ready right after an input transfer");

    // Flagged results (invalid or busy) carry a zero envelope.
    a_note_zero_env: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != 2'(ladsr_pkg::ST_OK)) |-> (o_envelope == '0))
        else $error("non-zero envelope on a flagged result");

    // Envelope never exceeds full scale.
    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_envelope) <= 32'(ladsr_pkg::ONE_INT)))
        else $error("envelope above full scale");

    // Busy only while a ramp is running.
    a_busy_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == 2'(ladsr_pkg::ST_BUSY)) |->
        (o_phase == 3'(ladsr_pkg::PH_ATTACK) || o_phase == 3'(ladsr_pkg::PH_DECAY) ||
         o_phase == 3'(ladsr_pkg::PH_RELEASE)))
        else $error("busy status outside attack, decay or release");

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_envelope) && $stable(o_status) &&
                                  $stable(o_phase)))
        else $error("stalled result changed");

endmodule

bind linear_adsr_envelope_top ladsr_checker u_ladsr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_envelope (o_envelope),
    .o_status   (o_status),
    .o_phase    (o_phase)
);

@@ test/tb_linear_adsr_envelope_top.sv @@
// Self-checking testbench of the linear ADSR envelope generator top level.
`timescale 1ns / 100ps

module tb_linear_adsr_envelope_top;

    // Longest stretch without any transfer or register write before the run
    // is declared hung. The long receiver hold-off below stays well under it.
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_WAIT  = 24;
    localparam int PHASE_ITEMS  = 240;
    localparam int PHASE_COUNT  = 8;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = ladsr_pkg::REG_ATTACK;
    logic [15:0] i_cfg_data  = '0;
    logic        i_valid     = 1'b0;
    logic [1:0]  i_action    = ladsr_pkg::ACT_TICK;
    logic [15:0] i_intensity = '0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_envelope;
    logic [1:0]  o_status;
    logic [2:0]  o_phase;

    linear_adsr_envelope_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_intensity (i_intensity),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_envelope  (o_envelope),
        .o_status    (o_status),
        .o_phase     (o_phase)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Envelope predictor: register copies and generator state, starting
    // from the reset values of the block.
    // ------------------------------------------------------------------
    longint unsigned cfg_attack  = 480;
    longint unsigned cfg_decay   = 480;
    longint unsigned cfg_release = 480;
    longint unsigned cfg_sustain = 16384;

    ladsr_pkg::t_phase env_phase = ladsr_pkg::PH_IDLE;
    longint unsigned   ramp_pos  = 0;
    longint unsigned   level     = 0;
    longint unsigned   held_int  = 0;

    ladsr_pkg::t_result pending_results[$];

    // Decay ramp: from full scale down toward the sustain level.
    function automatic longint unsigned decay_level(longint unsigned pos, longint unsigned sus);
        if (cfg_decay == 0 || pos >= cfg_decay)
            return 64'(ladsr_pkg::ONE_INT);
        return sus + ((ladsr_pkg::ONE_INT - sus) * (cfg_decay - pos)) / cfg_decay;
    endfunction

    // Compute the result of one item and advance the generator state.
    function automatic ladsr_pkg::t_result predict_envelope(ladsr_pkg::t_action act,
                                                            logic [15:0] inten);
        ladsr_pkg::t_result res;
        longint unsigned    sus;
        res.envelope = '0;
        res.status   = ladsr_pkg::ST_OK;
        sus = (cfg_sustain > ladsr_pkg::ONE_INT) ? 64'(ladsr_pkg::ONE_INT) : cfg_sustain;
        if (act == ladsr_pkg::ACT_TICK) begin
            res.envelope = ladsr_pkg::ENV_W'((held_int * level) >> ladsr_pkg::FRAC_BITS);
            case (env_phase)
                ladsr_pkg::PH_ATTACK: begin
                    ramp_pos++;
                    if (ramp_pos < cfg_attack) begin
                        level = (ramp_pos * ladsr_pkg::ONE_INT) / cfg_attack;
                    end else begin
                        env_phase = ladsr_pkg::PH_DECAY;
                        ramp_pos  = 0;
                        level     = decay_level(64'd0, sus);
                    end
                end
                ladsr_pkg::PH_DECAY: begin
                    ramp_pos++;
                    if (ramp_pos < cfg_decay) begin
                        level = decay_level(ramp_pos, sus);
                    end else begin
                        env_phase = ladsr_pkg::PH_SUSTAIN;
                        ramp_pos  = 0;
                        level     = sus;
                    end
                end
                ladsr_pkg::PH_RELEASE: begin
                    ramp_pos++;
                    if (ramp_pos < cfg_release) begin
                        level = (sus * (cfg_release - ramp_pos)) / cfg_release;
                    end else begin
                        env_phase = ladsr_pkg::PH_IDLE;
                        ramp_pos  = 0;
                        held_int  = 0;
                        level     = 0;
                    end
                end
                default: ;
            endcase
        end else if (act == ladsr_pkg::ACT_ILLEGAL || inten > ladsr_pkg::ONE_INT) begin
            res.status = ladsr_pkg::ST_INVALID;
        end else if (act == ladsr_pkg::ACT_ON) begin
            if (env_phase == ladsr_pkg::PH_IDLE) begin
                held_int  = 64'(inten);
                env_phase = ladsr_pkg::PH_ATTACK;
                ramp_pos  = 0;
                level     = 0;
            end else if (env_phase != ladsr_pkg::PH_SUSTAIN) begin
                res.status = ladsr_pkg::ST_BUSY;
            end
        end else begin
            if (env_phase != ladsr_pkg::PH_IDLE && env_phase != ladsr_pkg::PH_RELEASE) begin
                env_phase = ladsr_pkg::PH_RELEASE;
                ramp_pos  = 0;
                level     = sus;
            end
        end
        res.phase = env_phase;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checker and watchdog. Outputs are sampled at the rising edge,
    // before the block's own updates land, so the order of processes within
    // a step does not matter.
    // ------------------------------------------------------------------
    int                 mismatches  = 0;
    int                 quiet_count = 0;
    ladsr_pkg::t_result oldest;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result envelope %0d status %0d phase %0d",
                                 $time, o_envelope, o_status, o_phase);
                end else begin
                    oldest = pending_results.pop_front();
                    if (o_envelope !== oldest.envelope || o_status !== oldest.status ||
                        o_phase !== oldest.phase) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch env %0d/%0d sts %0d/%0d ph %0d/%0d (exp/act)",
                                     $time, oldest.envelope, o_envelope, oldest.status,
                                     o_status, oldest.phase, o_phase);
                    end
                end
            end
            // Track register writes so the predictor sees the live values.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ladsr_pkg::REG_ATTACK:  cfg_attack  = 64'(i_cfg_data);
                    ladsr_pkg::REG_DECAY:   cfg_decay   = 64'(i_cfg_data);
                    ladsr_pkg::REG_RELEASE: cfg_release = 64'(i_cfg_data);
                    ladsr_pkg::REG_SUSTAIN: cfg_sustain = 64'(i_cfg_data);
                    default: ;
                endcase
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall) || i_cfg_we)
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: draw a stall of random length before each result, none in
    // calm stretches. On request, hold off for a long stretch so the block
    // fills up and stalls its input while the sender keeps offering.
    // ------------------------------------------------------------------
    bit calm          = 1'b0;
    bit hold_off_req  = 1'b0;

    initial begin
        int pause;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                pause = HOLD_CYCLES;
            end else begin
                pause = calm ? 0 : $urandom_range(0, 5);
            end
            if (pause > 0) begin
                i_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offer one item after a random gap and hold it until the transfer.
    // Valid stays high after the transfer when the next gap is zero; a
    // fixed expectation replaces the predicted one when the row's fixed flag is set.
    task automatic send_item(input ladsr_pkg::t_action act, input logic [15:0] inten,
                             input bit fixed, input ladsr_pkg::t_result want);
        int                 gap;
        ladsr_pkg::t_result guess;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= act;
        i_intensity <= inten;
        do @(posedge i_clk); while (o_stall);
        guess = predict_envelope(act, inten);
        pending_results.push_back(fixed ? want : guess);
    endtask

    // Drop valid, wait for every outstanding result, then let the block
    // finish whatever it still has in flight.
    task automatic drain_results(input int extra);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Write all four registers back to back while the block is idle.
    task automatic load_config(input logic [15:0] atk, input logic [15:0] dec,
                               input logic [15:0] rel, input logic [15:0] sus);
        ladsr_pkg::t_reg_idx idx [4];
        logic [15:0]         vals [4];
        idx  = '{ladsr_pkg::REG_ATTACK, ladsr_pkg::REG_DECAY, ladsr_pkg::REG_RELEASE,
                 ladsr_pkg::REG_SUSTAIN};
        vals = '{atk, dec, rel, sus};
        drain_results(SETTLE_WAIT);
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Directed table: item rows and register rows, walked in order.
    typedef struct {
        bit                  is_cfg;
        ladsr_pkg::t_action  act;
        logic [15:0]         inten;
        bit                  fixed;
        ladsr_pkg::t_result  want;
        logic [15:0]         atk, dec, rel, sus;
    } t_opening_row;

    t_opening_row opening_rows[$];

    task automatic row_item(input ladsr_pkg::t_action act, input logic [15:0] inten,
                            input bit fixed, input ladsr_pkg::t_result want);
        t_opening_row r;
        r = '{is_cfg: 1'b0, act: act, inten: inten, fixed: fixed, want: want,
              atk: '0, dec: '0, rel: '0, sus: '0};
        opening_rows.push_back(r);
    endtask

    task automatic row_cfg(input logic [15:0] atk, input logic [15:0] dec,
                           input logic [15:0] rel, input logic [15:0] sus);
        t_opening_row r;
        r = '{is_cfg: 1'b1, act: ladsr_pkg::ACT_TICK, inten: '0, fixed: 1'b0, want: '0,
              atk: atk, dec: dec, rel: rel, sus: sus};
        opening_rows.push_back(r);
    endtask

    initial begin
        int                 p;
        int                 n;
        int                 roll;
        ladsr_pkg::t_action act;
        logic [15:0]        inten;

        // Reset values of the registers: every ramp 480 samples, half scale sustain.
        // Tick in idle, the invalid cases, note-off in idle, then into attack.
        row_item(ladsr_pkg::ACT_TICK, 16'hFFFF, 1,
                 '{16'd0, ladsr_pkg::ST_OK, ladsr_pkg::PH_IDLE});
        row_item(ladsr_pkg::ACT_ON, 16'd32769, 1,
                 '{16'd0, ladsr_pkg::ST_INVALID, ladsr_pkg::PH_IDLE});
        row_item(ladsr_pkg::ACT_OFF, 16'd32769, 1,
                 '{16'd0, ladsr_pkg::ST_INVALID, ladsr_pkg::PH_IDLE});
        row_item(ladsr_pkg::ACT_ILLEGAL, 16'd0, 1,
                 '{16'd0, ladsr_pkg::ST_INVALID, ladsr_pkg::PH_IDLE});
        row_item(ladsr_pkg::ACT_OFF, 16'd0, 1,
                 '{16'd0, ladsr_pkg::ST_OK, ladsr_pkg::PH_IDLE});
        row_item(ladsr_pkg::ACT_ON, 16'd32768, 1,
                 '{16'd0, ladsr_pkg::ST_OK, ladsr_pkg::PH_ATTACK});
        row_item(ladsr_pkg::ACT_ON, 16'd0, 1,
                 '{16'd0, ladsr_pkg::ST_BUSY, ladsr_pkg::PH_ATTACK});
        row_item(ladsr_pkg::ACT_TICK, 16'd0, 1,
                 '{16'd0, ladsr_pkg::ST_OK, ladsr_pkg::PH_ATTACK});
        row_item(ladsr_pkg::ACT_TICK, 16'd0, 0, '0);
        // Note-off in attack jumps straight to release at the sustain level.
        row_item(ladsr_pkg::ACT_OFF, 16'd0, 1,
                 '{16'd0, ladsr_pkg::ST_OK, ladsr_pkg::PH_RELEASE});
        row_item(ladsr_pkg::ACT_ON, 16'd100, 1,
                 '{16'd0, ladsr_pkg::ST_BUSY, ladsr_pkg::PH_RELEASE});
        // Shorten the ramps while release is under way, then a full cycle.
        row_cfg(16'd2, 16'd2, 16'd2, 16'd20000);
        row_item(ladsr_pkg::ACT_TICK, 16'd0, 0, '0);
        row_item(ladsr_pkg::ACT_TICK, 16'd0, 0, '0);
        row_item(ladsr_pkg::ACT_ON, 16'd12345, 1,
                 '{16'd0, ladsr_pkg::ST_OK, ladsr_pkg::PH_ATTACK});
        row_item(ladsr_pkg::ACT_TICK, 16'd0, 0, '0);
        row_item(ladsr_pkg::ACT_TICK, 16'd0, 0, '0);
        row_item(ladsr_pkg::ACT_TICK, 16'd0, 0, '0);
        row_item(ladsr_pkg::ACT_TICK, 16'd0, 0, '0);
        row_item(ladsr_pkg::ACT_ON, 16'd5, 1,
                 '{16'd0, ladsr_pkg::ST_OK, ladsr_pkg::PH_SUSTAIN});
        row_item(ladsr_pkg::ACT_OFF, 16'd0, 1,
                 '{16'd0, ladsr_pkg::ST_OK, ladsr_pkg::PH_RELEASE});
        // Zero lengths and a sustain level above one.
        row_cfg(16'd0, 16'd0, 16'd0, 16'hFFFF);
        row_item(ladsr_pkg::ACT_TICK, 16'd0, 0, '0);
        row_item(ladsr_pkg::ACT_ON, 16'd32768, 1,
                 '{16'd0, ladsr_pkg::ST_OK, ladsr_pkg::PH_ATTACK});
        row_item(ladsr_pkg::ACT_TICK, 16'd0, 0, '0);
        row_item(ladsr_pkg::ACT_TICK, 16'd0, 0, '0);
        row_item(ladsr_pkg::ACT_OFF, 16'd0, 1,
                 '{16'd0, ladsr_pkg::ST_OK, ladsr_pkg::PH_RELEASE});
        row_item(ladsr_pkg::ACT_TICK, 16'd0, 0, '0);

        // Hold reset once before the run starts.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_rows[k]) begin
            if (opening_rows[k].is_cfg)
                load_config(opening_rows[k].atk, opening_rows[k].dec,
                            opening_rows[k].rel, opening_rows[k].sus);
            else
                send_item(opening_rows[k].act, opening_rows[k].inten,
                          opening_rows[k].fixed, opening_rows[k].want);
        end

        // Random phases, each under its own register setting. Short ramps
        // dominate so that whole attack-decay-sustain-release cycles occur.
        for (p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: load_config(16'd1, 16'd1, 16'd1, 16'd32768);
                1: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
                2: load_config(16'd0, 16'd0, 16'd0, 16'd0);
                3: load_config(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                               16'($urandom_range(0, 6)), 16'hFFFF);
                default: load_config(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                                     16'($urandom_range(0, 12)),
                                     16'($urandom_range(0, ladsr_pkg::ONE_INT)));
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Alternate stretches without idling on either side.
                if (n % 64 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if (p == 4 && n == 60)
                    hold_off_req = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 58) begin
                    act   = ladsr_pkg::ACT_TICK;
                    inten = 16'($urandom);
                end else if (roll < 73) begin
                    act   = ladsr_pkg::ACT_ON;
                    inten = 16'($urandom_range(0, ladsr_pkg::ONE_INT));
                end else if (roll < 87) begin
                    act   = ladsr_pkg::ACT_OFF;
                    inten = 16'($urandom_range(0, ladsr_pkg::ONE_INT));
                end else if (roll < 93) begin
                    act   = ladsr_pkg::ACT_ILLEGAL;
                    inten = 16'($urandom);
                end else begin
                    // Note item with an out-of-range intensity.
                    act   = ($urandom_range(0, 1) != 0) ? ladsr_pkg::ACT_ON : ladsr_pkg::ACT_OFF;
                    inten = 16'($urandom_range(ladsr_pkg::ONE_INT + 1, 65535));
                end
                send_item(act, inten, 1'b0, '0);
            end
        end

        // Let everything drain, then a short tail for stray results.
        drain_results(40);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ linear_adsr_envelope_top.f @@
src/ladsr_pkg.sv
src/ladsr_div.sv
src/ladsr_core.sv
src/linear_adsr_envelope_top.sv
src/ladsr_checker.sv
test/tb_linear_adsr_envelope_top.sv
